/* design/sector_file_signature_scanner_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sector file signature scanner
// Shared concurrent assertion forms, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef SECTOR_FILE_SIGNATURE_SCANNER_DEFINES_SVH
`define SECTOR_FILE_SIGNATURE_SCANNER_DEFINES_SVH

// property holds at every edge outside reset
`define SFSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sfss_pkg.sv */
// ---------------------------------------------------------------------------
// sfss_pkg
// Types, constants and footer patterns of the sector signature scanner.
// ---------------------------------------------------------------------------
package sfss_pkg;

  localparam int unsigned SECTOR_BYTES_DEF = 512;
  localparam int unsigned HDR_LEN          = 12;
  localparam int unsigned WIN_CELLS        = 8;
  localparam int unsigned FOOT_END_W       = 10;
  localparam logic [31:0] RIFF_EXTRA       = 32'd8;

  typedef enum logic [1:0] {
    SEARCH_NONE = 2'd0,
    SEARCH_JPEG = 2'd1,
    SEARCH_PDF  = 2'd2,
    SEARCH_PNG  = 2'd3
  } search_e;

  typedef enum logic [2:0] {
    HDR_NONE = 3'd0,
    HDR_JPEG = 3'd1,
    HDR_PDF  = 3'd2,
    HDR_PNG  = 3'd3,
    HDR_WEBP = 3'd4
  } hdr_type_e;

  // footer patterns, newest byte in the low byte
  localparam logic [63:0] JPEG_FOOT = 64'h0000_0000_0000_FFD9;
  localparam logic [63:0] PDF_FOOT  = 64'h0000_0025_2545_4F46;
  localparam logic [63:0] PNG_FOOT  = 64'h4945_4E44_AE42_6082;
  localparam int unsigned JPEG_LEN  = 2;
  localparam int unsigned PDF_LEN   = 5;
  localparam int unsigned PNG_LEN   = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sector_end;
    logic [1:0] search_type;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]            header_type;
    logic [31:0]           riff_size;
    logic                  footer_found;
    logic [FOOT_END_W-1:0] footer_end;
  } out_beat_t;

  typedef struct packed {
    logic jpeg;
    logic pdf;
    logic png;
  } foot_hit_t;

  typedef struct packed {
    hdr_type_e   header_type;
    logic [31:0] riff_size;
  } hdr_res_t;

endpackage

/* design/sector_file_signature_scanner.sv */
// ---------------------------------------------------------------------------
// sector_file_signature_scanner
// Byte-serial sector scanner: header classification, RIFF size and the
// earliest footer match, one result beat per sector.
// ---------------------------------------------------------------------------
//  channel  | dir | payload           | beat
//  in       | in  | sfss_pkg::in_beat_t  | one sector byte
//  out      | out | sfss_pkg::out_beat_t | one result per sector
//
//  One byte per cycle; the window is an eight-cell shift chain compared in
//  the same cycle the byte enters. The result is registered and appears in
//  the cycle after the last byte is taken. Input stalls only while a result
//  beat waits in the output register and is not taken in that cycle.
//  Reset clears position, held search type and match state; no clear pass.
// ---------------------------------------------------------------------------
`include "sector_file_signature_scanner_defines.svh"

module sector_file_signature_scanner #(
  parameter int unsigned SECTOR_BYTES = sfss_pkg::SECTOR_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfss_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfss_pkg::out_beat_t out_beat_o
);

  localparam int unsigned POS_W = $clog2(SECTOR_BYTES + 1);

  logic [POS_W-1:0]  pos_q, pos_new, pos_inc, end_q, end_new;
  sfss_pkg::search_e held_q, type_eff;
  logic              found_q, found_new, hit, found_now;
  logic              in_acc, active, shift_en, first, sector_done;
  logic              out_valid_q;
  sfss_pkg::out_beat_t out_q;

  logic [7:0]          chain [sfss_pkg::WIN_CELLS+1];
  sfss_pkg::foot_hit_t cell_hit [sfss_pkg::WIN_CELLS];
  logic [sfss_pkg::WIN_CELLS-1:0] hit_jpeg, hit_pdf, hit_png;
  sfss_pkg::hdr_res_t  hdr_res;
  logic [POS_W+sfss_pkg::FOOT_END_W-1:0] end_ext;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign sector_done = in_acc && in_beat_i.sector_end;
  assign active      = pos_q < POS_W'(SECTOR_BYTES);
  assign shift_en    = in_acc && active;
  assign first       = pos_q == '0;
  assign pos_inc     = pos_q + POS_W'(1);
  assign pos_new     = shift_en ? pos_inc : pos_q;
  assign type_eff    = first ? sfss_pkg::search_e'(in_beat_i.search_type) : held_q;

  assign chain[0] = in_beat_i.data_byte;

  for (genvar i = 0; i < sfss_pkg::WIN_CELLS; i++) begin : g_cell
    sfss_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (shift_en),
      .byte_i (chain[i]),
      .byte_o (chain[i+1]),
      .hit_o  (cell_hit[i])
    );
    assign hit_jpeg[i] = cell_hit[i].jpeg;
    assign hit_pdf[i]  = cell_hit[i].pdf;
    assign hit_png[i]  = cell_hit[i].png;
  end

  always_comb begin
    unique case (type_eff)
      sfss_pkg::SEARCH_JPEG: hit = (&hit_jpeg) &&
                                   (pos_q >= POS_W'(sfss_pkg::JPEG_LEN - 1));
      sfss_pkg::SEARCH_PDF:  hit = (&hit_pdf) &&
                                   (pos_q >= POS_W'(sfss_pkg::PDF_LEN - 1));
      sfss_pkg::SEARCH_PNG:  hit = (&hit_png) &&
                                   (pos_q >= POS_W'(sfss_pkg::PNG_LEN - 1));
      default:               hit = 1'b0;
    endcase
  end

  assign found_now = shift_en && !found_q && hit;
  assign found_new = found_q || found_now;
  assign end_new   = found_now ? pos_inc : end_q;
  assign end_ext   = {{sfss_pkg::FOOT_END_W{1'b0}}, end_new};

  sfss_header #(
    .POS_W (POS_W)
  ) u_header (
    .clk_i     (clk_i),
    .we_i      (shift_en),
    .pos_i     (pos_q),
    .pos_new_i (pos_new),
    .byte_i    (in_beat_i.data_byte),
    .res_o     (hdr_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      held_q      <= sfss_pkg::SEARCH_NONE;
      found_q     <= 1'b0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_beat_i.sector_end) begin
          pos_q   <= '0;
          held_q  <= sfss_pkg::SEARCH_NONE;
          found_q <= 1'b0;
          end_q   <= '0;
        end else begin
          pos_q   <= pos_new;
          found_q <= found_new;
          end_q   <= end_new;
          if (first) begin
            held_q <= type_eff;
          end
        end
      end
      if (sector_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sector_done) begin
      out_q.header_type  <= hdr_res.header_type;
      out_q.riff_size    <= hdr_res.riff_size;
      out_q.footer_found <= found_new;
      out_q.footer_end   <= end_ext[sfss_pkg::FOOT_END_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `SFSS_ASSERT(a_pos_bound, pos_q <= POS_W'(SECTOR_BYTES), "position past sector size")
  `SFSS_ASSERT(a_end_found, !found_q || (end_q != '0 && end_q <= pos_q), "bad footer end")
  `SFSS_ASSERT(a_end_clear, found_q || end_q == '0, "footer end set without match")
  `SFSS_ASSERT_NEXT(a_close, sector_done, out_valid_q && pos_q == '0 && !found_q, "sector open")

endmodule

/* design/sfss_cell.sv */
// ---------------------------------------------------------------------------
// sfss_cell
// One byte of the sliding match window; compares its incoming byte against
// each footer pattern at its offset and hands its byte to the next cell.
// ---------------------------------------------------------------------------
module sfss_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [7:0]          byte_i,
  output logic [7:0]          byte_o,
  output sfss_pkg::foot_hit_t hit_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // offsets past a pattern's length always agree
  assign hit_o.jpeg = (IDX >= sfss_pkg::JPEG_LEN) ||
                      (byte_i == sfss_pkg::JPEG_FOOT[8*IDX +: 8]);
  assign hit_o.pdf  = (IDX >= sfss_pkg::PDF_LEN) ||
                      (byte_i == sfss_pkg::PDF_FOOT[8*IDX +: 8]);
  assign hit_o.png  = (IDX >= sfss_pkg::PNG_LEN) ||
                      (byte_i == sfss_pkg::PNG_FOOT[8*IDX +: 8]);

endmodule

/* design/sfss_header.sv */
// ---------------------------------------------------------------------------
// sfss_header
// Captures the first twelve sector bytes, classifies the header and forms
// the RIFF size from the bytes taken so far.
// ---------------------------------------------------------------------------
module sfss_header #(
  parameter int unsigned POS_W = 10
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [POS_W-1:0]   pos_i,
  input  logic [POS_W-1:0]   pos_new_i,
  input  logic [7:0]         byte_i,
  output sfss_pkg::hdr_res_t res_o
);

  logic [7:0] hdr_q [sfss_pkg::HDR_LEN];
  logic [7:0] eff   [sfss_pkg::HDR_LEN];
  logic [sfss_pkg::HDR_LEN-1:0] vld;
  logic [sfss_pkg::HDR_LEN-1:0] wsel;

  for (genvar i = 0; i < sfss_pkg::HDR_LEN; i++) begin : g_hdr
    assign wsel[i] = we_i && (pos_i == POS_W'(i));
    assign vld[i]  = POS_W'(i) < pos_new_i;
    assign eff[i]  = wsel[i] ? byte_i : hdr_q[i];

    always_ff @(posedge clk_i) begin
      if (wsel[i]) begin
        hdr_q[i] <= byte_i;
      end
    end
  end

  logic is_jpeg, is_pdf, is_png, is_webp;
  logic [7:0] r4, r5, r6, r7;

  assign is_jpeg = vld[0] && eff[0] == 8'hFF && vld[1] && eff[1] == 8'hD8 &&
                   vld[2] && eff[2] == 8'hFF;
  assign is_pdf  = vld[0] && eff[0] == 8'h25 && vld[1] && eff[1] == 8'h50 &&
                   vld[2] && eff[2] == 8'h44 && vld[3] && eff[3] == 8'h46;
  assign is_png  = vld[0] && eff[0] == 8'h89 && vld[1] && eff[1] == 8'h50 &&
                   vld[2] && eff[2] == 8'h4E && vld[3] && eff[3] == 8'h47;
  assign is_webp = vld[0] && eff[0] == 8'h52 && vld[1] && eff[1] == 8'h49 &&
                   vld[2] && eff[2] == 8'h46 && vld[3] && eff[3] == 8'h46 &&
                   vld[8] && eff[8] == 8'h57 && vld[9] && eff[9] == 8'h45 &&
                   vld[10] && eff[10] == 8'h42 && vld[11] && eff[11] == 8'h50;

  always_comb begin
    priority if (is_jpeg) begin
      res_o.header_type = sfss_pkg::HDR_JPEG;
    end else if (is_pdf) begin
      res_o.header_type = sfss_pkg::HDR_PDF;
    end else if (is_png) begin
      res_o.header_type = sfss_pkg::HDR_PNG;
    end else if (is_webp) begin
      res_o.header_type = sfss_pkg::HDR_WEBP;
    end else begin
      res_o.header_type = sfss_pkg::HDR_NONE;
    end
  end

  // bytes not yet taken read as zero
  assign r4 = vld[4] ? eff[4] : 8'h00;
  assign r5 = vld[5] ? eff[5] : 8'h00;
  assign r6 = vld[6] ? eff[6] : 8'h00;
  assign r7 = vld[7] ? eff[7] : 8'h00;

  assign res_o.riff_size = {r7, r6, r5, r4} + sfss_pkg::RIFF_EXTRA;

endmodule
